/* hw/rtl/sbct_pkg.sv */
// Shared types and constants for the swept box against convex brush tracer.
// Used by the divider, the controller, the datapath and the top level; no dependencies.
package sbct_pkg;

  localparam logic signed [63:0] EPS_Q   = 64'sd4096;      // 1/16 in Q16.16
  localparam logic        [16:0] ONE_Q   = 17'd65536;      // 1.0 in Q16.16
  localparam logic        [31:0] Q_MAX   = 32'h7FFF_FFFF;  // saturated quotient
  localparam logic         [4:0] PLANE_COUNT_RST = 5'd6;

  // configuration register indexes
  localparam logic [2:0] CFG_BOX_MIN_X   = 3'd0;
  localparam logic [2:0] CFG_BOX_MIN_Y   = 3'd1;
  localparam logic [2:0] CFG_BOX_MIN_Z   = 3'd2;
  localparam logic [2:0] CFG_BOX_MAX_X   = 3'd3;
  localparam logic [2:0] CFG_BOX_MAX_Y   = 3'd4;
  localparam logic [2:0] CFG_BOX_MAX_Z   = 3'd5;
  localparam logic [2:0] CFG_PLANE_COUNT = 3'd6;

  // operand pair for the multiply-accumulate
  typedef enum logic [2:0] {
    V_CORNER,  // normal . box corner
    V_ORG,     // normal . origin
    V_DIR,     // normal . movement
    V_HIT,     // normal . hit point
    V_STEP     // hit point = origin + movement * fraction
  } vsel_t;

  typedef enum logic [2:0] {
    R_NONE,
    R_STUCK,   // start test found no clearing plane
    R_NOHIT,   // no entry plane
    R_HIT0,    // entry plane, pulled back to zero
    R_HITDIV   // entry plane, pulled-back quotient
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BL_HEAD, S_BL_DOT, S_BL_WR,
    S_ST_HEAD, S_ST_DORG, S_ST_EV1, S_ST_DDIR, S_ST_EV2,
    S_TR_HEAD, S_TR_DDIR, S_TR_EV1, S_TR_DORG, S_TR_EV2,
    S_TR_DIV1, S_TR_EV3, S_TR_HIT,
    S_Q_HEAD, S_Q_DOT, S_Q_EV,
    S_TR_DIV2, S_OUT
  } state_t;

  typedef struct packed {
    logic       plane_we;
    logic       latch;
    logic       mac_en;
    logic [1:0] mac_c;
    vsel_t      vsel;
    logic       acc_clr;
    logic       bloat_we;
    logic       save_den;
    logic       save_d;
    logic       save_f;
    logic       save_stuck;
    logic       div_start;
    logic       div_eps;
    res_t       res;
  } cmd_t;

  typedef struct packed {
    logic dval_ge0;
    logic dval_gt_neg_eps;
    logic dval_gt0;
    logic acc_ge0;
    logic f_gt_frac;
    logic d_lt_eps;
    logic div_done;
  } sts_t;

endpackage

/* hw/rtl/sbct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/sbct_div.sv */
// Restoring divider: floor(num * 65536 / den), saturated to 2^31 - 1.
// One quotient bit per cycle. Depends on sbct_pkg.
module sbct_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic        [31:0] quot
);
  import sbct_pkg::*;

  logic        busy;
  logic  [4:0] cnt;
  logic [63:0] rem;
  logic [63:0] dn;
  logic [30:0] ns;
  logic [63:0] trial;
  logic        ge;

  assign trial = {rem[62:0], ns[30]};
  assign ge    = (trial >= dn);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num >= (den <<< 15)) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= 5'd31;
        end
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= (num >= (den <<< 15)) ? Q_MAX : 32'd0;
      rem  <= $unsigned(num) >> 15;
      ns   <= {num[14:0], 16'b0};
      dn   <= $unsigned(den);
    end else if (busy) begin
      rem  <= ge ? (trial - dn) : trial;
      quot <= {quot[30:0], ge};
      ns   <= {ns[29:0], 1'b0};
    end
  end
endmodule

/* hw/rtl/sbct_dp.sv */
// Datapath: plane store, multiply-accumulate, distance terms, divider, result.
// Depends on sbct_pkg, sbct_ram and sbct_div.
module sbct_dp #(
  parameter int MAX_PLANES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sbct_pkg::cmd_t                  cmd,
  input  logic [$clog2(MAX_PLANES)-1:0]   rd_addr,
  input  logic                      [3:0] entry_index,
  input  logic signed              [31:0] vec     [3],
  input  logic signed              [31:0] dirv    [3],
  input  logic signed              [31:0] scalar,
  input  logic signed              [31:0] box_min [3],
  input  logic signed              [31:0] box_max [3],
  output sbct_pkg::sts_t                  sts,
  output logic                            start_solid,
  output logic                     [16:0] fraction,
  output logic                            normal_valid,
  output logic signed              [31:0] impact  [3]
);
  import sbct_pkg::*;

  localparam int AW = $clog2(MAX_PLANES);

  logic                    plane_we;
  logic             [127:0] plane_rd;
  logic              [31:0] bloat_rd;
  logic              [31:0] bloat_wd;
  logic signed       [31:0] pn [3];
  logic signed       [31:0] pdist;
  logic signed       [31:0] pbloat;

  logic signed       [31:0] org [3];
  logic signed       [31:0] dir_r [3];
  logic              [16:0] frac;
  logic signed       [33:0] hit [3];
  logic signed       [63:0] acc;
  logic signed       [63:0] den_r;
  logic signed       [63:0] d_save;
  logic              [16:0] f_save;
  logic                     stuck_v;
  logic signed       [31:0] stuck_n [3];
  logic signed       [31:0] nrm_p [3];

  logic              [1:0]  ci;
  logic signed       [31:0] a_op;
  logic signed       [33:0] b_op;
  logic signed       [17:0] bhi;
  logic signed       [16:0] blo;
  logic signed       [49:0] p1;
  logic signed       [48:0] p2;
  logic                     mv;
  logic                     mhit;
  logic              [1:0]  mc;
  logic signed       [63:0] fm;
  logic signed       [63:0] dval;
  logic signed       [63:0] div_num;
  logic                     div_done;
  logic              [31:0] quot;
  logic signed       [31:0] corner;

  // plane store: normal x, y, z then distance
  assign plane_we = cmd.plane_we && (32'(entry_index) < 32'(MAX_PLANES));

  sbct_ram #(.WIDTH(128), .DEPTH(MAX_PLANES)) u_planes (
    .clk   (clk),
    .we    (plane_we),
    .waddr (AW'(entry_index)),
    .wdata ({scalar, vec[2], vec[1], vec[0]}),
    .raddr (rd_addr),
    .rdata (plane_rd)
  );

  sbct_ram #(.WIDTH(32), .DEPTH(MAX_PLANES)) u_bloat (
    .clk   (clk),
    .we    (cmd.bloat_we),
    .waddr (rd_addr),
    .wdata (bloat_wd),
    .raddr (rd_addr),
    .rdata (bloat_rd)
  );

  assign pn[0]  = plane_rd[31:0];
  assign pn[1]  = plane_rd[63:32];
  assign pn[2]  = plane_rd[95:64];
  assign pdist  = plane_rd[127:96];
  assign pbloat = bloat_rd;

  always_comb begin
    if (acc > 64'sd2147483647) begin
      bloat_wd = 32'h7FFF_FFFF;
    end else if (acc < -64'sd2147483648) begin
      bloat_wd = 32'h8000_0000;
    end else begin
      bloat_wd = acc[31:0];
    end
  end

  // operand selection
  always_comb begin
    ci     = (cmd.mac_c == 2'd3) ? 2'd0 : cmd.mac_c;
    corner = pn[ci][31] ? box_max[ci] : box_min[ci];
    a_op   = pn[ci];
    case (cmd.vsel)
      V_CORNER: b_op = {{2{corner[31]}}, corner};
      V_ORG:    b_op = {{2{org[ci][31]}}, org[ci]};
      V_DIR:    b_op = {{2{dir_r[ci][31]}}, dir_r[ci]};
      V_HIT:    b_op = hit[ci];
      V_STEP: begin
        a_op = dir_r[ci];
        b_op = {17'b0, f_save};
      end
      default:  b_op = '0;
    endcase
    bhi = b_op[33:16];
    blo = {1'b0, b_op[15:0]};
  end

  // floor(a * b / 65536) = a * hi + floor(a * lo / 65536)
  always_ff @(posedge clk) begin
    p1   <= a_op * bhi;
    p2   <= a_op * blo;
    mc   <= ci;
    mhit <= (cmd.vsel == V_STEP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else begin
      mv <= cmd.mac_en;
    end
  end

  assign fm   = {{14{p1[49]}}, p1} + {{31{p2[48]}}, p2[48:16]};
  assign dval = acc - {{32{pdist[31]}}, pdist} + {{32{pbloat[31]}}, pbloat};

  always_ff @(posedge clk) begin
    if (mv && !mhit) begin
      acc <= acc + fm;
    end else if (cmd.acc_clr) begin
      acc <= '0;
    end
    if (mv && mhit) begin
      hit[mc] <= {{2{org[mc][31]}}, org[mc]} + fm[33:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      org   <= vec;
      dir_r <= dirv;
      if (scalar[31]) begin
        frac <= '0;
      end else if (scalar > 32'sd65536) begin
        frac <= ONE_Q;
      end else begin
        frac <= scalar[16:0];
      end
    end
    if (cmd.save_den) begin
      den_r <= -acc;
    end
    if (cmd.save_d) begin
      d_save <= dval;
      nrm_p  <= pn;
    end
    if (cmd.save_f) begin
      f_save <= quot[16:0];
    end
    if (cmd.save_stuck) begin
      stuck_n <= pn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stuck_v <= 1'b0;
    end else if (cmd.latch) begin
      stuck_v <= 1'b0;
    end else if (cmd.save_stuck) begin
      stuck_v <= 1'b1;
    end
  end

  assign div_num = cmd.div_eps ? (d_save - EPS_Q) : dval;

  sbct_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    sts.dval_ge0        = !dval[63];
    sts.dval_gt_neg_eps = (dval > -EPS_Q);
    sts.dval_gt0        = (dval > 64'sd0);
    sts.acc_ge0         = !acc[63];
    sts.f_gt_frac       = (quot > {15'b0, frac});
    sts.d_lt_eps        = (d_save < EPS_Q);
    sts.div_done        = div_done;
  end

  always_ff @(posedge clk) begin
    case (cmd.res)
      R_STUCK: begin
        start_solid  <= !stuck_v;
        fraction     <= '0;
        normal_valid <= stuck_v;
        for (int i = 0; i < 3; i++) begin
          impact[i] <= stuck_v ? stuck_n[i] : 32'sd0;
        end
      end
      R_NOHIT: begin
        start_solid  <= 1'b0;
        fraction     <= frac;
        normal_valid <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          impact[i] <= 32'sd0;
        end
      end
      R_HIT0: begin
        start_solid  <= 1'b0;
        fraction     <= '0;
        normal_valid <= 1'b1;
        impact       <= nrm_p;
      end
      R_HITDIV: begin
        start_solid  <= 1'b0;
        fraction     <= (quot > {15'b0, frac}) ? frac : quot[16:0];
        normal_valid <= 1'b1;
        impact       <= nrm_p;
      end
      default: begin
      end
    endcase
  end
endmodule

/* hw/rtl/sbct_ctrl.sv */
// Controller: sequences the plane walks of one trace and the handshakes.
// Depends on sbct_pkg; drives the datapath through cmd_t, reads sts_t.
module sbct_ctrl #(
  parameter int MAX_PLANES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          mode,
  output logic                          s_tready,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic                    [4:0] plane_count,
  input  sbct_pkg::sts_t                sts,
  output sbct_pkg::cmd_t                cmd,
  output logic [$clog2(MAX_PLANES)-1:0] rd_addr
);
  import sbct_pkg::*;

  localparam int AW = $clog2(MAX_PLANES);
  localparam int CW = $clog2(MAX_PLANES + 1);

  state_t        state, state_next;
  logic [CW-1:0] p, p_next;
  logic [CW-1:0] q, q_next;
  logic    [1:0] c, c_next;
  logic [CW-1:0] count;
  logic          dot_end;

  always_comb begin
    if (32'(plane_count) > 32'(MAX_PLANES)) begin
      count = CW'(MAX_PLANES);
    end else begin
      count = CW'(plane_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      p     <= '0;
      q     <= '0;
      c     <= '0;
    end else begin
      state <= state_next;
      p     <= p_next;
      q     <= q_next;
      c     <= c_next;
    end
  end

  assign rd_addr = (state inside {S_Q_HEAD, S_Q_DOT, S_Q_EV}) ? q[AW-1:0] : p[AW-1:0];
  assign dot_end = (c == 2'd3);

  always_comb begin
    state_next = state;
    p_next     = p;
    q_next     = q;
    c_next     = '0;
    cmd        = '0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;

    // three-term dot: issue x, y, z, then drain
    if (state inside {S_BL_DOT, S_ST_DORG, S_ST_DDIR, S_TR_DDIR, S_TR_DORG,
                      S_TR_HIT, S_Q_DOT}) begin
      cmd.mac_en  = !dot_end;
      cmd.mac_c   = c;
      cmd.acc_clr = (c == 2'd0);
      c_next      = dot_end ? 2'd0 : c + 2'd1;
    end

    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (mode) begin
            cmd.latch  = 1'b1;
            p_next     = '0;
            q_next     = '0;
            state_next = S_BL_HEAD;
          end else begin
            cmd.plane_we = 1'b1;
          end
        end
      end
      S_BL_HEAD: begin
        if (p == count) begin
          p_next     = '0;
          state_next = S_ST_HEAD;
        end else begin
          state_next = S_BL_DOT;
        end
      end
      S_BL_DOT: begin
        cmd.vsel = V_CORNER;
        if (dot_end) state_next = S_BL_WR;
      end
      S_BL_WR: begin
        cmd.bloat_we = 1'b1;
        p_next       = p + 1'b1;
        state_next   = S_BL_HEAD;
      end
      S_ST_HEAD: begin
        if (p == count) begin
          cmd.res    = R_STUCK;
          state_next = S_OUT;
        end else begin
          state_next = S_ST_DORG;
        end
      end
      S_ST_DORG: begin
        cmd.vsel = V_ORG;
        if (dot_end) state_next = S_ST_EV1;
      end
      S_ST_EV1: begin
        if (sts.dval_ge0) begin
          p_next     = '0;
          state_next = S_TR_HEAD;
        end else if (sts.dval_gt_neg_eps) begin
          state_next = S_ST_DDIR;
        end else begin
          p_next     = p + 1'b1;
          state_next = S_ST_HEAD;
        end
      end
      S_ST_DDIR: begin
        cmd.vsel = V_DIR;
        if (dot_end) state_next = S_ST_EV2;
      end
      S_ST_EV2: begin
        if (sts.acc_ge0) begin
          p_next     = '0;
          state_next = S_TR_HEAD;
        end else begin
          cmd.save_stuck = 1'b1;
          p_next         = p + 1'b1;
          state_next     = S_ST_HEAD;
        end
      end
      S_TR_HEAD: begin
        if (p == count) begin
          cmd.res    = R_NOHIT;
          state_next = S_OUT;
        end else begin
          state_next = S_TR_DDIR;
        end
      end
      S_TR_DDIR: begin
        cmd.vsel = V_DIR;
        if (dot_end) state_next = S_TR_EV1;
      end
      S_TR_EV1: begin
        if (sts.acc_ge0) begin
          p_next     = p + 1'b1;
          state_next = S_TR_HEAD;
        end else begin
          cmd.save_den = 1'b1;
          state_next   = S_TR_DORG;
        end
      end
      S_TR_DORG: begin
        cmd.vsel = V_ORG;
        if (dot_end) state_next = S_TR_EV2;
      end
      S_TR_EV2: begin
        if (!sts.dval_ge0) begin
          p_next     = p + 1'b1;
          state_next = S_TR_HEAD;
        end else begin
          cmd.save_d    = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = S_TR_DIV1;
        end
      end
      S_TR_DIV1: begin
        if (sts.div_done) state_next = S_TR_EV3;
      end
      S_TR_EV3: begin
        if (sts.f_gt_frac) begin
          p_next     = p + 1'b1;
          state_next = S_TR_HEAD;
        end else begin
          cmd.save_f = 1'b1;
          state_next = S_TR_HIT;
        end
      end
      S_TR_HIT: begin
        cmd.vsel = V_STEP;
        if (dot_end) begin
          q_next     = '0;
          state_next = S_Q_HEAD;
        end
      end
      S_Q_HEAD: begin
        if (q == count) begin
          if (sts.d_lt_eps) begin
            cmd.res    = R_HIT0;
            state_next = S_OUT;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_eps   = 1'b1;
            state_next    = S_TR_DIV2;
          end
        end else if (q == p) begin
          q_next = q + 1'b1;
        end else begin
          state_next = S_Q_DOT;
        end
      end
      S_Q_DOT: begin
        cmd.vsel = V_HIT;
        if (dot_end) state_next = S_Q_EV;
      end
      S_Q_EV: begin
        if (sts.dval_gt0) begin
          p_next     = p + 1'b1;
          state_next = S_TR_HEAD;
        end else begin
          q_next     = q + 1'b1;
          state_next = S_Q_HEAD;
        end
      end
      S_TR_DIV2: begin
        if (sts.div_done) begin
          cmd.res    = R_HITDIV;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_bloat_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.bloat_we |-> (p < count))
    else $error("bloat write beyond plane count");

  a_no_self_test: assert property (@(posedge clk) disable iff (rst)
    (state == S_Q_DOT) |-> (q != p))
    else $error("candidate plane tested against itself");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> ((p <= count) && (q <= count)))
    else $error("plane walk past plane count");

  a_div_started: assert property (@(posedge clk) disable iff (rst)
    ((state == S_TR_DIV1) && ($past(state) != S_TR_DIV1)) |-> $past(cmd.div_start))
    else $error("division wait entered without a start");
`endif
endmodule

/* hw/rtl/swept_box_convex_trace.sv */
// Top level of the swept box against convex brush tracer.
// Holds the configuration registers and ties sbct_ctrl to sbct_dp; uses sbct_pkg.
//
// Sweeps an axis-aligned box (box_min/box_max, Q16.16) from an origin along a
// movement vector against a convex brush of up to MAX_PLANES planes. A
// transaction with tuser = 0 loads one plane (normal in vec, distance in
// scalar) into slot entry_index; it gives no result.
// A transaction with tuser = 1 is a trace and gives exactly one result.
// Planes must be loaded before they are traced against. One item is worked
// on at a time. A trace forms the corner offsets, runs the start test and,
// per candidate entry plane, divides on the divider and tests the hit point
// against the other planes, then does the final pull-back division unless
// the entry distance is under epsilon. All steps use the single shared
// multiply-accumulate, which handles one vector component per cycle, and
// the bit-serial divider. Configuration must be written by the user only
// while the block is idle; the block itself does not enforce this. There
// is no clearing pass after reset.
module swept_box_convex_trace #(
  parameter int MAX_PLANES = 16
) (
  input  logic         clk,
  input  logic         rst,
  // slave side
  input  logic         s_tvalid,
  output logic         s_tready,
  // entry_index[3:0], vec_x[35:4], vec_y[67:36], vec_z[99:68], dir_x[131:100],
  // dir_y[163:132], dir_z[195:164], scalar[227:196], zero[231:228]
  input  logic [231:0] s_tdata,
  // mode[0]: 0 plane load, 1 trace
  input  logic         s_tuser,
  // master side
  output logic         m_tvalid,
  input  logic         m_tready,
  // start_solid[0], fraction[17:1], normal_valid[18], impact_x[50:19],
  // impact_y[82:51], impact_z[114:83], zero[119:115]
  output logic [119:0] m_tdata,
  // configuration
  input  logic         cfg_we,
  input  logic   [2:0] cfg_index,
  input  logic  [31:0] cfg_data
);
  import sbct_pkg::*;

  logic signed [31:0] box_min [3];
  logic signed [31:0] box_max [3];
  logic        [4:0]  plane_count;

  logic signed [31:0] vec  [3];
  logic signed [31:0] dirv [3];
  logic signed [31:0] scalar;

  cmd_t               cmd;
  sts_t               sts;
  logic [$clog2(MAX_PLANES)-1:0] rd_addr;

  logic               start_solid;
  logic        [16:0] fraction;
  logic               normal_valid;
  logic signed [31:0] impact [3];

  // configuration registers; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        box_min[i] <= '0;
        box_max[i] <= '0;
      end
      plane_count <= PLANE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_MIN_X:   box_min[0]  <= cfg_data;
        CFG_BOX_MIN_Y:   box_min[1]  <= cfg_data;
        CFG_BOX_MIN_Z:   box_min[2]  <= cfg_data;
        CFG_BOX_MAX_X:   box_max[0]  <= cfg_data;
        CFG_BOX_MAX_Y:   box_max[1]  <= cfg_data;
        CFG_BOX_MAX_Z:   box_max[2]  <= cfg_data;
        CFG_PLANE_COUNT: plane_count <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // input unpacking
  assign vec[0]  = s_tdata[35:4];
  assign vec[1]  = s_tdata[67:36];
  assign vec[2]  = s_tdata[99:68];
  assign dirv[0] = s_tdata[131:100];
  assign dirv[1] = s_tdata[163:132];
  assign dirv[2] = s_tdata[195:164];
  assign scalar  = s_tdata[227:196];

  sbct_ctrl #(.MAX_PLANES(MAX_PLANES)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .mode        (s_tuser),
    .s_tready    (s_tready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .plane_count (plane_count),
    .sts         (sts),
    .cmd         (cmd),
    .rd_addr     (rd_addr)
  );

  sbct_dp #(.MAX_PLANES(MAX_PLANES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .entry_index  (s_tdata[3:0]),
    .vec          (vec),
    .dirv         (dirv),
    .scalar       (scalar),
    .box_min      (box_min),
    .box_max      (box_max),
    .sts          (sts),
    .start_solid  (start_solid),
    .fraction     (fraction),
    .normal_valid (normal_valid),
    .impact       (impact)
  );

  // result stays in the datapath registers until the transaction completes
  assign m_tdata = {5'b0, impact[2], impact[1], impact[0], normal_valid,
                    fraction, start_solid};
endmodule
